// ----- rtl/sme_pkg.sv -----
// ----------------------------------------------------------------------------
// sme_pkg
// Types and constants shared by the square matrix engine: input and result
// item layouts, operation and result codes, and sequencer states.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned MATRIX_DIM_DEF = 8;
  localparam int unsigned ELEM_WIDTH_DEF = 16;

  localparam int unsigned IDX_W     = 3;
  localparam int unsigned IN_ELEM_W = 16;
  localparam int unsigned VAL_W     = 36;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
  localparam logic              REG_SIZE   = 1'b0;

  typedef enum logic [2:0] {
    FUNC_LOAD_A    = 3'd0,
    FUNC_LOAD_B    = 3'd1,
    FUNC_UPDATE_A  = 3'd2,
    FUNC_SWAP_ROWS = 3'd3,
    FUNC_SWAP_COLS = 3'd4,
    FUNC_SUM       = 3'd5,
    FUNC_PROD      = 3'd6,
    FUNC_DIAG      = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    KIND_ACK  = 3'd0,
    KIND_SUM  = 3'd1,
    KIND_PROD = 3'd2,
    KIND_MAIN = 3'd3,
    KIND_SEC  = 3'd4,
    KIND_ERR  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SWAP_RD,
    ST_SWAP_WR1,
    ST_SWAP_WR2,
    ST_MAC_ISSUE,
    ST_MAC_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    func_e                        func;
    logic [IDX_W-1:0]             index_first;
    logic [IDX_W-1:0]             index_second;
    logic signed [IN_ELEM_W-1:0]  elem_value;
  } in_item_t;

  typedef struct packed {
    kind_e                    out_kind;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [VAL_W-1:0]  out_value;
    logic                     last;
  } out_item_t;

endpackage

// ----- rtl/square_matrix_engine.sv -----
// ----------------------------------------------------------------------------
// square_matrix_engine
// Two square signed matrices A and B in on-chip memories, with loads,
// updates, row and column swaps, element-wise sum, product and diagonal sums
// computed by one shared multiply/add unit under a small sequencer.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_ready_o is high only while the sequencer
// is idle, and the result register lets the next item in while the last
// result still waits. With n the active size, a row swap walks all
// MATRIX_DIM columns and a column swap only the n active rows; the sum and
// product each emit n*n elements and the diagonals two sums. Each result
// goes through the single multiply-accumulate path: one memory read pair
// per cycle, a multiply stage and an accumulate stage, drained before each
// element is emitted. There is no clearing pass; matrix entries hold
// garbage until written.
module square_matrix_engine
  import sme_pkg::*;
#(
  parameter int unsigned MATRIX_DIM = MATRIX_DIM_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int unsigned DEPTH = MATRIX_DIM * MATRIX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW    = ELEM_WIDTH;

  function automatic logic [AW-1:0] pos(input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col);
    pos = AW'(int'(row) * MATRIX_DIM + int'(col));
  endfunction

  // Configuration
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] n_eff;
  logic [IDX_W-1:0]  nm1;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIZE) ? {{(PDATA_W-SIZE_W){1'b0}}, size_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SIZE)) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (size_q == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_q > SIZE_W'(MATRIX_DIM)) begin
      n_eff = SIZE_W'(MATRIX_DIM);
    end else begin
      n_eff = size_q;
    end
  end
  assign nm1 = IDX_W'(n_eff - SIZE_W'(1));

  // Sequencer state and registers
  state_e state_q, state_d;
  in_item_t cur_q;
  logic err_q, err_d;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic signed [VAL_W-1:0] acc_q, acc_d, term_q, term_d;
  logic iss_v_q, term_v_q;
  logic out_valid_q, out_valid_d;
  out_item_t out_item_q, emit_item;

  // Memories
  logic [EW-1:0] mem_a [DEPTH];
  logic [EW-1:0] mem_b [DEPTH];
  logic [EW-1:0] rd_a0_q, rd_a1_q, rd_b_q;
  logic          rd_en;
  logic [AW-1:0] a0_addr, a1_addr, b_addr;
  logic          wa_en, wb_en;
  logic [AW-1:0] wa_addr;
  logic [EW-1:0] wa_data, elem_store;

  logic range_err, emit_fire, is_last;
  logic [AW-1:0] s0_addr, s1_addr, mac_a_addr, mac_b_addr;
  logic [IDX_W-1:0] k_lim, swap_lim;
  logic signed [2*EW-1:0] prod_full;
  logic signed [VAL_W-1:0] a_ext, b_ext;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign range_err = ({1'b0, cur_q.index_first} >= n_eff) ||
                     ({1'b0, cur_q.index_second} >= n_eff);
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign elem_store = EW'($signed(cur_q.elem_value));

  assign k_lim    = (cur_q.func == FUNC_SUM) ? '0 : nm1;
  assign swap_lim = (cur_q.func == FUNC_SWAP_ROWS) ? IDX_W'(MATRIX_DIM - 1) : nm1;

  // Address generation
  always_comb begin
    if (cur_q.func == FUNC_SWAP_ROWS) begin
      s0_addr = pos(cur_q.index_first, k_q);
      s1_addr = pos(cur_q.index_second, k_q);
    end else begin
      s0_addr = pos(k_q, cur_q.index_first);
      s1_addr = pos(k_q, cur_q.index_second);
    end
    case (cur_q.func)
      FUNC_SUM: begin
        mac_a_addr = pos(r_q, c_q);
        mac_b_addr = pos(r_q, c_q);
      end
      FUNC_PROD: begin
        mac_a_addr = pos(r_q, k_q);
        mac_b_addr = pos(k_q, c_q);
      end
      default: begin
        mac_a_addr = (c_q == '0) ? pos(k_q, k_q) : pos(k_q, nm1 - k_q);
        mac_b_addr = pos(r_q, c_q);
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if ((cur_q.func < FUNC_SUM) && range_err) begin
          state_d = ST_EMIT;
        end else begin
          case (cur_q.func)
            FUNC_SWAP_ROWS, FUNC_SWAP_COLS: state_d = ST_SWAP_RD;
            FUNC_SUM, FUNC_PROD, FUNC_DIAG: state_d = ST_MAC_ISSUE;
            default:                        state_d = ST_EMIT;
          endcase
        end
      end
      ST_SWAP_RD:  state_d = ST_SWAP_WR1;
      ST_SWAP_WR1: state_d = ST_SWAP_WR2;
      ST_SWAP_WR2: state_d = (k_q == swap_lim) ? ST_EMIT : ST_SWAP_RD;
      ST_MAC_ISSUE: begin
        if (k_q == k_lim) state_d = ST_MAC_DRAIN;
      end
      ST_MAC_DRAIN: begin
        if (!iss_v_q && !term_v_q) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire) state_d = is_last ? ST_IDLE : ST_MAC_ISSUE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result fields for the element or acknowledgement being emitted
  always_comb begin
    emit_item = '{out_kind: KIND_ACK, out_row: '0, out_col: '0,
                  out_value: '0, last: 1'b1};
    is_last = 1'b1;
    if (err_q) begin
      emit_item.out_kind = KIND_ERR;
    end else begin
      case (cur_q.func)
        FUNC_SUM, FUNC_PROD: begin
          emit_item.out_kind  = (cur_q.func == FUNC_SUM) ? KIND_SUM : KIND_PROD;
          emit_item.out_row   = r_q;
          emit_item.out_col   = c_q;
          emit_item.out_value = acc_q;
          is_last = (r_q == nm1) && (c_q == nm1);
        end
        FUNC_DIAG: begin
          emit_item.out_kind  = (c_q == '0) ? KIND_MAIN : KIND_SEC;
          emit_item.out_value = acc_q;
          is_last = (c_q != '0);
        end
        default: begin
          emit_item.out_kind = KIND_ACK;
        end
      endcase
    end
    emit_item.last = is_last;
  end

  // Datapath control
  always_comb begin
    err_d   = err_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    acc_d   = term_v_q ? (acc_q + term_q) : acc_q;
    rd_en   = 1'b0;
    a0_addr = s0_addr;
    a1_addr = s1_addr;
    b_addr  = mac_b_addr;
    wa_en   = 1'b0;
    wb_en   = 1'b0;
    wa_addr = pos(cur_q.index_first, cur_q.index_second);
    wa_data = elem_store;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    case (state_q)
      ST_DISPATCH: begin
        err_d = (cur_q.func < FUNC_SUM) && range_err;
        r_d   = '0;
        c_d   = '0;
        k_d   = '0;
        acc_d = '0;
        if (!range_err) begin
          wa_en = (cur_q.func == FUNC_LOAD_A) || (cur_q.func == FUNC_UPDATE_A);
          wb_en = (cur_q.func == FUNC_LOAD_B);
        end
      end
      ST_SWAP_RD: begin
        rd_en = 1'b1;
      end
      ST_SWAP_WR1: begin
        wa_en   = 1'b1;
        wa_addr = s0_addr;
        wa_data = rd_a1_q;
      end
      ST_SWAP_WR2: begin
        wa_en   = 1'b1;
        wa_addr = s1_addr;
        wa_data = rd_a0_q;
        k_d     = (k_q == swap_lim) ? '0 : k_q + IDX_W'(1);
      end
      ST_MAC_ISSUE: begin
        rd_en   = 1'b1;
        a0_addr = mac_a_addr;
        k_d     = (k_q == k_lim) ? '0 : k_q + IDX_W'(1);
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          acc_d       = '0;
          k_d         = '0;
          if (cur_q.func == FUNC_DIAG) begin
            c_d = IDX_W'(1);
          end else if (c_q == nm1) begin
            c_d = '0;
            r_d = r_q + IDX_W'(1);
          end else begin
            c_d = c_q + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Shared unit: multiply for products, add for sums, pass A for diagonals
  assign prod_full = $signed(rd_a0_q) * $signed(rd_b_q);
  assign a_ext = VAL_W'($signed(rd_a0_q));
  assign b_ext = (cur_q.func == FUNC_SUM) ? VAL_W'($signed(rd_b_q)) : '0;
  assign term_d = (cur_q.func == FUNC_PROD) ? VAL_W'(prod_full) : (a_ext + b_ext);

  always_ff @(posedge clk_i) begin
    if (wa_en) mem_a[wa_addr] <= wa_data;
    if (wb_en) mem_b[pos(cur_q.index_first, cur_q.index_second)] <= elem_store;
    if (rd_en) begin
      rd_a0_q <= mem_a[a0_addr];
      rd_a1_q <= mem_a[a1_addr];
      rd_b_q  <= mem_b[b_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) cur_q <= in_item_i;
    if (iss_v_q) term_q <= term_d;
    if (emit_fire) out_item_q <= emit_item;
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      err_q       <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      iss_v_q     <= 1'b0;
      term_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      r_q         <= r_d;
      c_q         <= c_d;
      k_q         <= k_d;
      iss_v_q     <= (state_q == ST_MAC_ISSUE);
      term_v_q    <= iss_v_q;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
